/* rtl/u2u_pkg.sv */
// u2u_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// used by the front decoder, the run queue, the byte serializer and the top level
`default_nettype none

package u2u_pkg;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_CONT  = 3'd1;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd2;
    localparam logic [2:0] ST_TOO_BIG   = 3'd3;
    localparam logic [2:0] ST_SURROGATE = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // code point limits
    localparam logic [20:0] CP_MAX      = 21'h10ffff;
    localparam logic [20:0] CP_BMP_MAX  = 21'h00ffff;
    localparam logic [20:0] CP_SUR_LO   = 21'h00d800;
    localparam logic [20:0] CP_SUR_HI   = 21'h00dfff;
    localparam logic [15:0] HI_SUR_BASE = 16'hd800 - 16'h0040;
    localparam logic [15:0] LO_SUR_BASE = 16'hdc00;

    // run queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one queued run: the results caused by one input transaction
    typedef struct packed {
        logic [15:0] unit_hi;    // first code unit (the only one for a bmp char)
        logic [15:0] unit_lo;    // low surrogate when two_units is set
        logic        two_units;
        logic        is_status;  // status-only result, no data octets
        logic        le;         // octet order captured at decode time
        logic        last;       // run closes the string
        logic [2:0]  status;
        logic [31:0] length;     // octets produced for the string so far
    } t_run;

endpackage

`default_nettype wire

/* rtl/u2u_front.sv */
// u2u_front: utf-8 decoder that classifies each octet and builds output runs
// depends on u2u_pkg
`default_nettype none

module u2u_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_last_in,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    output      logic          o_push,
    output      u2u_pkg::t_run o_run
);

    logic [1:0]  r_due,  n_due;
    logic [20:0] r_acc,  n_acc;
    logic [2:0]  r_err,  n_err;
    logic [31:0] r_len,  n_len;
    logic        r_le;

    logic [20:0] acc_shift;
    logic [20:0] cp;
    logic        emit;
    logic        two;

    assign acc_shift = {r_acc[14:0], i_in_byte[5:0]};

    always_comb begin
        n_due = r_due;
        n_acc = r_acc;
        n_err = r_err;
        emit  = 1'b0;
        cp    = 21'd0;
        if (r_err == u2u_pkg::ST_OK) begin
            if (r_due != 2'd0) begin
                if (i_in_byte[7:6] != 2'b10) begin
                    n_err = u2u_pkg::ST_BAD_CONT;
                end else begin
                    n_acc = acc_shift;
                    n_due = r_due - 2'd1;
                    if (r_due == 2'd1) begin
                        if (acc_shift > u2u_pkg::CP_MAX) begin
                            n_err = u2u_pkg::ST_TOO_BIG;
                        end else if (acc_shift >= u2u_pkg::CP_SUR_LO &&
                                     acc_shift <= u2u_pkg::CP_SUR_HI) begin
                            n_err = u2u_pkg::ST_SURROGATE;
                        end else begin
                            emit = 1'b1;
                            cp   = acc_shift;
                        end
                    end
                end
            end else if (i_in_byte[7] == 1'b0) begin
                emit = 1'b1;
                cp   = {13'd0, i_in_byte};
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_acc = {16'd0, i_in_byte[4:0]};
                n_due = 2'd1;
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_acc = {17'd0, i_in_byte[3:0]};
                n_due = 2'd2;
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_acc = {18'd0, i_in_byte[2:0]};
                n_due = 2'd3;
            end else begin
                n_err = u2u_pkg::ST_BAD_LEAD;
            end
            if (i_last_in && n_err == u2u_pkg::ST_OK && n_due != 2'd0) begin
                n_err = u2u_pkg::ST_TRUNCATED;
            end
        end
    end

    assign two   = (cp > u2u_pkg::CP_BMP_MAX);
    assign n_len = emit ? (r_len + (two ? 32'd4 : 32'd2)) : r_len;

    always_comb begin
        o_run.unit_hi   = two ? (u2u_pkg::HI_SUR_BASE + {5'd0, cp[20:10]}) : cp[15:0];
        o_run.unit_lo   = u2u_pkg::LO_SUR_BASE | {6'd0, cp[9:0]};
        o_run.two_units = two;
        o_run.is_status = !emit;
        o_run.le        = r_le;
        o_run.last      = i_last_in;
        o_run.status    = emit ? u2u_pkg::ST_OK : n_err;
        o_run.length    = n_len;
    end

    // an octet that completes nothing and ends nothing produces no run
    assign o_push = i_accept && (emit || (i_last_in && n_err != u2u_pkg::ST_OK));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due <= 2'd0;
            r_acc <= 21'd0;
            r_err <= u2u_pkg::ST_OK;
            r_len <= 32'd0;
            r_le  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_le <= i_cfg_wdata;
            end
            if (i_accept) begin
                if (i_last_in) begin
                    r_due <= 2'd0;
                    r_acc <= 21'd0;
                    r_err <= u2u_pkg::ST_OK;
                    r_len <= 32'd0;
                end else begin
                    r_due <= n_due;
                    r_acc <= n_acc;
                    r_err <= n_err;
                    r_len <= n_len;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/u2u_queue.sv */
// u2u_queue: short run queue between the decoder and the serializer
// depends on u2u_pkg
`default_nettype none

module u2u_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire u2u_pkg::t_run i_run,
    input  wire logic          i_pop,
    output      logic          o_valid,
    output      logic          o_full,
    output      u2u_pkg::t_run o_run
);

    u2u_pkg::t_run r_mem [u2u_pkg::Q_DEPTH];
    logic [u2u_pkg::Q_AW-1:0] r_wptr;
    logic [u2u_pkg::Q_AW-1:0] r_rptr;
    logic [u2u_pkg::Q_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (u2u_pkg::Q_AW+1)'(u2u_pkg::Q_DEPTH));
    assign o_run   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/u2u_back.sv */
// u2u_back: serializes queued runs into utf-16 octets behind an output register
// depends on u2u_pkg
`default_nettype none

module u2u_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire u2u_pkg::t_run i_run,
    output      logic          o_pop,
    output      logic          o_valid,
    input  wire logic          i_stall,
    output      logic [7:0]    o_out_byte,
    output      logic          o_byte_valid,
    output      logic          o_run_last,
    output      logic          o_string_done,
    output      logic [2:0]    o_status,
    output      logic [31:0]   o_out_length
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic       load;
    logic [1:0] idx_last;
    logic       at_last;
    logic       done;
    logic [15:0] unit;
    logic [7:0]  octet;

    assign load     = !r_valid || !i_stall;
    assign idx_last = i_run.is_status ? 2'd0 : (i_run.two_units ? 2'd3 : 2'd1);
    assign at_last  = (r_idx == idx_last);
    assign done     = at_last && i_run.last;
    assign unit     = r_idx[1] ? i_run.unit_lo : i_run.unit_hi;
    assign octet    = (r_idx[0] ^ i_run.le) ? unit[7:0] : unit[15:8];
    assign o_pop    = load && i_q_valid && at_last;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            o_out_byte    <= i_run.is_status ? 8'd0 : octet;
            o_byte_valid  <= !i_run.is_status;
            o_run_last    <= at_last;
            o_string_done <= done;
            o_status      <= done ? i_run.status : u2u_pkg::ST_OK;
            o_out_length  <= (done && !i_run.is_status) ? i_run.length : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= at_last ? 2'd0 : (r_idx + 2'd1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/utf8_to_utf16_transcoder_core.sv */
// utf8_to_utf16_transcoder_core: utf-8 octet stream in, utf-16 octets out
// path: a result is written into the run queue, then loaded into the output register
// throughput: one input octet per cycle while the four-entry run queue has room;
//   the serializer sends one octet per cycle while not stalled, so a bmp char is sent as two octets
// reset: synchronous active-low; clears decoder state, empties the queue, big-endian order
// depends on u2u_pkg, u2u_front, u2u_queue, u2u_back
`default_nettype none

module utf8_to_utf16_transcoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output      logic        o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_last_in,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    // output channel
    output      logic        o_valid,
    input  wire logic        i_stall,
    output      logic [7:0]  o_out_byte,
    output      logic        o_byte_valid,
    output      logic        o_run_last,
    output      logic        o_string_done,
    output      logic [2:0]  o_status,
    output      logic [31:0] o_out_length
);

    u2u_pkg::t_run front_run;
    u2u_pkg::t_run head_run;
    logic          push;
    logic          pop;
    logic          q_valid;
    logic          q_full;
    logic          accept;

    // input transaction is taken whenever the queue has room, even for
    // octets that produce no run
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    // decoder: gathers code points and turns each octet into at most one run
    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_last_in   (i_last_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push),
        .o_run       (front_run)
    );

    // decouples the decoder from output back-pressure
    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (front_run),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_run   (head_run)
    );

    // serializer: one octet or status result per output transaction
    u2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_run         (head_run),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done),
        .o_status      (o_status),
        .o_out_length  (o_out_length)
    );

endmodule

`default_nettype wire

/* test/utf8_to_utf16_transcoder_checker.sv */
// utf8_to_utf16_transcoder_checker: watches both channels and the byte order register,
// predicts every utf-16 octet and status transaction and compares field by field
// depends on u2u_pkg for status codes and code point limits

module utf8_to_utf16_transcoder_checker
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_byte_valid,
    input  logic        i_out_run_last,
    input  logic        i_out_string_done,
    input  logic [2:0]  i_out_status,
    input  logic [31:0] i_out_length,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_result_count
);

    typedef struct packed {
        logic [7:0]  octet;
        logic        has_data;
        logic        run_last;
        logic        done;
        logic [2:0]  status;
        logic [31:0] length;
    } t_utf16_octet;

    t_utf16_octet expected_octets_q[$];

    // predictor state
    logic        le_order;
    logic [1:0]  conts_due;
    logic [20:0] code_point;
    logic [2:0]  string_error;
    logic [31:0] octets_so_far;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 40)
            $display("[%0t] output transaction %0d: %s got 0x%0h expected 0x%0h",
                     $time, o_result_count, what, got, want);
        o_fail_count++;
    endtask

    // one utf-8 octet in, zero to four expected transactions out
    task automatic predict_octet(input logic [7:0] octet, input logic last);
        logic [15:0]  units [0:1];
        t_utf16_octet caused [0:3];
        int           nunits, nres, k, j;
        nunits = 0;
        nres   = 0;
        if (string_error == ST_OK) begin
            if (conts_due != 2'd0) begin
                if (octet[7:6] != 2'b10) begin
                    string_error = ST_BAD_CONT;
                end else begin
                    code_point = {code_point[14:0], octet[5:0]};
                    conts_due  = conts_due - 2'd1;
                    if (conts_due == 2'd0) begin
                        if (code_point > CP_MAX) begin
                            string_error = ST_TOO_BIG;
                        end else if (code_point >= CP_SUR_LO && code_point <= CP_SUR_HI) begin
                            string_error = ST_SURROGATE;
                        end else if (code_point > CP_BMP_MAX) begin
                            units[0] = HI_SUR_BASE + {5'd0, code_point[20:10]};
                            units[1] = LO_SUR_BASE + {6'd0, code_point[9:0]};
                            nunits   = 2;
                        end else begin
                            units[0] = code_point[15:0];
                            nunits   = 1;
                        end
                    end
                end
            end else if (octet[7] == 1'b0) begin
                units[0] = {8'd0, octet};
                nunits   = 1;
            end else if (octet[7:5] == 3'b110) begin
                code_point = {16'd0, octet[4:0]};
                conts_due  = 2'd1;
            end else if (octet[7:4] == 4'b1110) begin
                code_point = {17'd0, octet[3:0]};
                conts_due  = 2'd2;
            end else if (octet[7:3] == 5'b11110) begin
                code_point = {18'd0, octet[2:0]};
                conts_due  = 2'd3;
            end else begin
                string_error = ST_BAD_LEAD;
            end
            if (last && string_error == ST_OK && conts_due != 2'd0)
                string_error = ST_TRUNCATED;
        end

        if (string_error == ST_OK) begin
            for (k = 0; k < nunits; k++) begin
                for (j = 0; j < 2; j++) begin
                    octets_so_far = octets_so_far + 32'd1;
                    caused[nres] = '{((j == 0) == le_order) ? units[k][7:0] : units[k][15:8],
                                     1'b1, 1'b0, 1'b0, ST_OK, 32'd0};
                    nres++;
                end
            end
            if (last && nres > 0) begin
                caused[nres-1].done   = 1'b1;
                caused[nres-1].length = octets_so_far;
            end
        end else if (last) begin
            caused[0] = '{8'd0, 1'b0, 1'b0, 1'b1, string_error, 32'd0};
            nres      = 1;
        end
        if (nres > 0)
            caused[nres-1].run_last = 1'b1;
        for (k = 0; k < nres; k++)
            expected_octets_q.push_back(caused[k]);

        if (last) begin
            conts_due     = 2'd0;
            code_point    = 21'd0;
            string_error  = ST_OK;
            octets_so_far = 32'd0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_utf16_octet want;
        if (!i_rst_n) begin
            expected_octets_q.delete();
            le_order      = 1'b0;
            conts_due     = 2'd0;
            code_point    = 21'd0;
            string_error  = ST_OK;
            octets_so_far = 32'd0;
        end else begin
            if (i_cfg_we)
                le_order = i_cfg_wdata;
            // output first, so a result can never match an expectation made at this edge
            if (i_out_valid === 1'b1 && !i_out_stall) begin
                o_result_count++;
                if (expected_octets_q.size() == 0) begin
                    report_mismatch("unexpected transaction, octet", 32'(i_out_byte), 32'd0);
                end else begin
                    want = expected_octets_q.pop_front();
                    if (i_out_byte !== want.octet)
                        report_mismatch("out_byte", 32'(i_out_byte), 32'(want.octet));
                    if (i_out_byte_valid !== want.has_data)
                        report_mismatch("byte_valid", 32'(i_out_byte_valid),
                                        32'(want.has_data));
                    if (i_out_run_last !== want.run_last)
                        report_mismatch("run_last", 32'(i_out_run_last), 32'(want.run_last));
                    if (i_out_string_done !== want.done)
                        report_mismatch("string_done", 32'(i_out_string_done), 32'(want.done));
                    if (i_out_status !== want.status)
                        report_mismatch("status", 32'(i_out_status), 32'(want.status));
                    if (i_out_length !== want.length)
                        report_mismatch("out_length", i_out_length, want.length);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_octet(i_in_byte, i_in_last);
        end
        o_pending <= expected_octets_q.size();
    end

endmodule

/* test/utf8_to_utf16_transcoder_core_tb.sv */
// utf8_to_utf16_transcoder_core_tb: drives utf-8 strings into the transcoder in both
// byte orders under random sender gaps and receiver stalls
// depends on utf8_to_utf16_transcoder_core and utf8_to_utf16_transcoder_checker

module utf8_to_utf16_transcoder_core_tb;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int PHASE_OCTETS  = 90;     // minimum random octets per byte order phase
    localparam int DRAIN_CYCLES  = 8;      // queue depth plus the output register, with margin
    localparam int LIMIT_CYCLES  = 200000;

    // kinds of damage put into a random string
    typedef enum int {
        FAULT_LEAD,    // stray continuation or f8..ff as lead
        FAULT_CONT,    // sequence broken by a non-continuation octet
        FAULT_BIG,     // four-octet form above 10ffff
        FAULT_SURR,    // surrogate code point, three or four octets
        FAULT_TRUNC,   // string ends inside a sequence
        FAULT_NOISE    // plain random octets
    } t_fault;

    // receiver behavior, changed after a random stretch
    typedef enum int {
        RX_FLOW,       // never stalls
        RX_CHOPPY,     // stalls half the time
        RX_CONGESTED   // stalls three quarters of the time
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } t_octet_item;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte      = 8'd0;
    logic        in_last      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic        cfg_wdata    = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  out_byte;
    logic        out_byte_valid;
    logic        out_run_last;
    logic        out_string_done;
    logic [2:0]  out_status;
    logic [31:0] out_length;

    int          pending_octets;
    int          mismatches;
    int          results_seen;

    // stimulus bookkeeping
    t_octet_item octet_q[$];       // octets waiting to be sent
    logic [7:0]  str_buf[$];       // string under construction
    int          octets_sent    = 0;
    int          string_count   = 0;
    int          faulty_strings = 0;
    int          order_writes   = 0;
    int          burst_left     = 0;

    t_rx_mode    rx_mode        = RX_FLOW;
    int          rx_mode_left   = 0;

    always #CLK_HALF clk = ~clk;

    utf8_to_utf16_transcoder_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_in_byte     (in_byte),
        .i_last_in     (in_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_out_byte    (out_byte),
        .o_byte_valid  (out_byte_valid),
        .o_run_last    (out_run_last),
        .o_string_done (out_string_done),
        .o_status      (out_status),
        .o_out_length  (out_length)
    );

    utf8_to_utf16_transcoder_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_byte         (in_byte),
        .i_in_last         (in_last),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_byte        (out_byte),
        .i_out_byte_valid  (out_byte_valid),
        .i_out_run_last    (out_run_last),
        .i_out_string_done (out_string_done),
        .i_out_status      (out_status),
        .i_out_length      (out_length),
        .o_pending         (pending_octets),
        .o_fail_count      (mismatches),
        .o_result_count    (results_seen)
    );

    // receiver stall pattern: a random mode held for a random stretch, flow mode
    // gives long runs with no stall at all
    always @(posedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, int'(RX_CONGESTED)));
            rx_mode_left <= $urandom_range(32, 160);
            out_stall    <= 1'b0;
        end else begin
            rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_FLOW:   out_stall <= 1'b0;
                RX_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
                default:   out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // string construction
    // ---------------------------------------------------------------------

    // move the string under construction to the send queue, last flag on its final octet
    task automatic close_string();
        t_octet_item item;
        int          k;
        for (k = 0; k < str_buf.size(); k++) begin
            item.octet = str_buf[k];
            item.last  = (k == str_buf.size() - 1);
            octet_q.push_back(item);
        end
        str_buf.delete();
        string_count++;
    endtask

    // utf-8 encode a code point in exactly nbytes octets; a short code point in a
    // long form gives an overlong sequence, which the block accepts
    task automatic put_char(input logic [20:0] cp, input int nbytes);
        logic [7:0] lead;
        int         k;
        case (nbytes)
            1:       lead = {1'b0, cp[6:0]};
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        str_buf.push_back(lead);
        for (k = nbytes - 2; k >= 0; k--)
            str_buf.push_back({2'b10, cp[6*k +: 6]});
    endtask

    // a well-formed character: ascii weighted, then 2, 3 and 4-octet forms
    task automatic put_random_char();
        int          nbytes;
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: nbytes = 1;
            4, 5:       nbytes = 2;
            6, 7:       nbytes = 3;
            default:    nbytes = 4;
        endcase
        case (nbytes)
            1:       cp = 21'($urandom_range(0, 'h7f));
            2:       cp = 21'($urandom_range('h80, 'h7ff));
            3:       cp = 21'($urandom_range('h800, 'hffff));
            default: cp = 21'($urandom_range('h10000, 'h10ffff));
        endcase
        // occasional overlong form
        if (nbytes > 1 && $urandom_range(0, 9) == 0) begin
            case (nbytes)
                2:       cp = 21'($urandom_range(0, 'h7f));
                3:       cp = 21'($urandom_range(0, 'h7ff));
                default: cp = 21'($urandom_range(0, 'hffff));
            endcase
        end
        // keep clear of the surrogate range
        if (cp >= 21'hd800 && cp <= 21'hdfff)
            cp = cp - 21'h800;
        put_char(cp, nbytes);
    endtask

    task automatic put_fault(input t_fault fault);
        int         nbytes, cut;
        logic [7:0] stray;
        nbytes = $urandom_range(2, 4);
        cut    = $urandom_range(1, nbytes - 1);
        case (fault)
            FAULT_LEAD: begin
                if ($urandom_range(0, 1) == 1)
                    str_buf.push_back(8'($urandom_range('h80, 'hbf)));
                else
                    str_buf.push_back(8'($urandom_range('hf8, 'hff)));
            end
            FAULT_CONT: begin
                put_char(21'($urandom_range(0, 'h10ffff)), nbytes);
                repeat (cut) void'(str_buf.pop_back());
                stray = 8'($urandom_range(0, 255));
                if (stray[7:6] == 2'b10)
                    stray[6] = 1'b1;
                str_buf.push_back(stray);
            end
            FAULT_BIG:  put_char(21'($urandom_range('h110000, 'h1fffff)), 4);
            FAULT_SURR: put_char(21'($urandom_range('hd800, 'hdfff)), $urandom_range(3, 4));
            FAULT_TRUNC: begin
                put_char(21'($urandom_range(0, 'h10ffff)), nbytes);
                repeat (cut) void'(str_buf.pop_back());
            end
            default: begin
                repeat ($urandom_range(1, 4))
                    str_buf.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // mostly clean strings of 1..8 characters; one in five gets a fault at a random
    // character, and after any fault but harmless noise the rest is dropped by the block
    task automatic build_random_string();
        int     nchars, fault_at, k;
        t_fault fault;
        nchars   = $urandom_range(1, 8);
        fault_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nchars - 1) : -1;
        fault    = t_fault'($urandom_range(0, int'(FAULT_NOISE)));
        if (fault_at >= 0)
            faulty_strings++;
        for (k = 0; k < nchars; k++) begin
            if (k == fault_at) begin
                put_fault(fault);
                if (fault == FAULT_TRUNC)
                    break;
            end else begin
                put_random_char();
            end
        end
        close_string();
    endtask

    // ---------------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------------

    // called at a rising edge; returns at the edge where the octet was taken, or after
    // the gap that ends a burst. valid stays high across a burst, then drops for a random gap
    task automatic send_octet(input t_octet_item item);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= item.octet;
        in_last  <= item.last;
        do
            @(posedge clk);
        while (in_stall);
        octets_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
    endtask

    task automatic send_queued();
        while (octet_q.size() > 0)
            send_octet(octet_q.pop_front());
        in_valid <= 1'b0;
    endtask

    // every expectation met, then a drain margin for octets that cause nothing
    task automatic wait_drained();
        @(posedge clk);
        while (pending_octets != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // byte order is only changed with the block empty
    task automatic set_byte_order(input logic lsb_first);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= lsb_first;
        @(posedge clk);
        cfg_we    <= 1'b0;
        order_writes++;
    endtask

    initial begin
        int phase;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings, big-endian
        set_byte_order(1'b0);
        // nul, 2, 3 and 4-octet chars, 10ffff as a surrogate pair, end on a 4-octet char
        str_buf = '{8'h00, 8'hc2, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        close_string();
        // overlong nul
        str_buf = '{8'hc0, 8'h80};
        close_string();
        // bad lead, the ascii after it is dropped
        str_buf = '{8'hff, 8'h41};
        close_string();
        // lead followed by ascii: bad continuation
        str_buf = '{8'he2, 8'h41};
        close_string();
        // 110000, above the unicode range
        str_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
        close_string();
        // d800 as a three-octet sequence
        str_buf = '{8'hed, 8'ha0, 8'h80};
        close_string();
        // 7f already sent, then the string stops inside a sequence
        str_buf = '{8'h7f, 8'he2, 8'h82};
        close_string();
        send_queued();

        // random phases alternating byte order, little-endian first
        for (phase = 1; phase <= 4; phase++) begin
            set_byte_order(phase % 2 == 1);
            while (octet_q.size() < PHASE_OCTETS)
                build_random_string();
            send_queued();
        end

        wait_drained();
        $display("sent %0d utf-8 octets in %0d strings, %0d with injected faults",
                 octets_sent, string_count, faulty_strings);
        $display("checked %0d utf-16 transactions over %0d byte order writes",
                 results_seen, order_writes);
        if (mismatches == 0 && pending_octets == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Regression FAIL");
        $finish;
    end

endmodule
